>>> src/mhsu_pkg.sv
package mhsu_pkg;

  localparam int NUM_HASHES   = 4;
  localparam int NUM_CFG_REGS = 2 * NUM_HASHES;
  localparam int COEF_W       = 8;
  localparam int ROW_W        = 12;
  localparam int COL_W        = 12;
  localparam int SIG_W        = 17;
  localparam int HASH_W       = 20;  // 255 + 255 * 4095 < 2**20
  localparam int CFG_IDX_W    = 4;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [SIG_W-1:0]  SENTINEL  = SIG_W'(99999);
  localparam logic [COEF_W-1:0] COEF_INIT = COEF_W'(1);

  typedef enum logic {
    CMD_SET  = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  typedef logic [NUM_HASHES-1:0][HASH_W-1:0] hash_vec_t;
  typedef logic [NUM_HASHES-1:0][SIG_W-1:0]  sig_row_t;

  // One classified item on its way from the front end to the back end
  typedef struct packed {
    logic             is_set;
    logic             in_range;
    logic [COL_W-1:0] col;
    hash_vec_t        hash;
  } work_t;

endpackage

>>> src/mhsu_ifs.sv
interface mhsu_item_if import mhsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [ROW_W-1:0] row_index;
  logic [COL_W-1:0] col_index;

  modport source (output valid, command, row_index, col_index, input ready);
  modport sink   (input valid, command, row_index, col_index, output ready);
endinterface

interface mhsu_result_if import mhsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SIG_W-1:0] signature0;
  logic [SIG_W-1:0] signature1;
  logic [SIG_W-1:0] signature2;
  logic [SIG_W-1:0] signature3;

  modport source (output valid, signature0, signature1, signature2, signature3,
                  input ready);
  modport sink   (input valid, signature0, signature1, signature2, signature3,
                  output ready);
endinterface

interface mhsu_cfg_if import mhsu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/mhsu_front.sv
module mhsu_front import mhsu_pkg::*; #(
  parameter int MAX_COLUMNS = 4096
) (
  input  logic  clk,
  input  logic  rst,
  mhsu_item_if.sink item,
  mhsu_cfg_if.sink  setup,
  input  logic  clearing,
  input  logic  q_full,
  output logic  push,
  output work_t push_data
);

  logic [NUM_HASHES-1:0][COEF_W-1:0] offset;
  logic [NUM_HASHES-1:0][COEF_W-1:0] slope;
  logic      stg_valid;
  work_t     stg;
  hash_vec_t hash_next;
  logic      accept;
  logic      cfg_hit;
  logic [$clog2(NUM_HASHES)-1:0] cfg_sel;

  assign setup.ready = 1'b1;
  assign cfg_hit = setup.valid
                && (setup.index < CFG_IDX_W'(NUM_CFG_REGS));
  assign cfg_sel = setup.index[$clog2(NUM_HASHES):1];

  assign push       = stg_valid && !q_full;
  assign push_data  = stg;
  assign item.ready = !clearing && (!stg_valid || !q_full);
  assign accept     = item.valid && item.ready;

  always_comb begin
    for (int k = 0; k < NUM_HASHES; k++) begin
      hash_next[k] = HASH_W'(offset[k]) + HASH_W'(slope[k]) * HASH_W'(item.row_index);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      for (int k = 0; k < NUM_HASHES; k++) begin
        offset[k] <= COEF_INIT;
        slope[k]  <= COEF_INIT;
      end
    end else begin
      // even index: offset, odd index: slope
      if (cfg_hit) begin
        if (setup.index[0]) begin
          slope[cfg_sel] <= setup.data;
        end else begin
          offset[cfg_sel] <= setup.data;
        end
      end
      if (accept) begin
        stg_valid <= 1'b1;
      end else if (push) begin
        stg_valid <= 1'b0;
      end
    end
    if (accept) begin
      stg.is_set   <= (item.command == CMD_SET);
      stg.in_range <= (32'(item.col_index) < MAX_COLUMNS);
      stg.col      <= item.col_index;
      stg.hash     <= hash_next;
    end
  end

endmodule

>>> src/mhsu_queue.sv
module mhsu_queue import mhsu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output work_t head
);

  work_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> src/mhsu_back.sv
module mhsu_back import mhsu_pkg::*; #(
  parameter int DEPTH = 4096
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  work_t head,
  output logic  pop,
  output logic  clearing,
  mhsu_result_if.source result
);

  localparam int AW = $clog2(DEPTH);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t           state;
  logic [AW-1:0]    clr_addr;
  work_t            cur;
  sig_row_t         mem [DEPTH];
  sig_row_t         rd_row;
  sig_row_t         new_row;
  sig_row_t         sentinel_row;
  sig_row_t         res_row;
  sig_row_t         wdata;
  logic [AW-1:0]    waddr;
  logic             mem_we;
  logic             out_free;
  logic             done;

  always_comb begin
    for (int k = 0; k < NUM_HASHES; k++) begin
      sentinel_row[k] = SENTINEL;
      // a hash at or above the sentinel can never win here
      if (cur.is_set && (cur.hash[k] < HASH_W'(rd_row[k]))) begin
        new_row[k] = cur.hash[k][SIG_W-1:0];
      end else begin
        new_row[k] = rd_row[k];
      end
    end
  end

  assign clearing = (state == S_CLEAR);
  assign pop      = (state == S_IDLE) && head_valid;
  assign out_free = !result.valid || result.ready;
  assign done     = (state == S_UPDATE) && out_free;
  assign mem_we   = clearing || (done && cur.is_set && cur.in_range);
  assign waddr    = clearing ? clr_addr : cur.col[AW-1:0];
  assign wdata    = clearing ? sentinel_row : new_row;

  assign result.signature0 = res_row[0];
  assign result.signature1 = res_row[1];
  assign result.signature2 = res_row[2];
  assign result.signature3 = res_row[3];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (pop) begin
      rd_row <= mem[head.col[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      result.valid <= 1'b0;
    end else begin
      // load a new result or drop the one just transferred
      if (done) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // hold here until the output register frees up
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
    if (pop) begin
      cur <= head;
    end
    if (done) begin
      res_row <= cur.in_range ? new_row : sentinel_row;
    end
  end

endmodule

>>> src/minhash_signature_update_core.sv
// An item passes through the front-end stage register, the queue and the back-end
// read and update states before its result is registered. The back end pops the next
// item only after the read-modify-write of the single-port signature memory is done.
// Reset: synchronous; hash coefficients go to 1, then a clearing pass writes the sentinel
// into every one of the min(MAX_COLUMNS, 4096) columns while no item is taken
// (configuration writes are taken throughout).
module minhash_signature_update_core import mhsu_pkg::*; #(
  parameter int MAX_COLUMNS = 4096
) (
  input logic clk,
  input logic rst,
  mhsu_item_if.sink      item,
  mhsu_cfg_if.sink       setup,
  mhsu_result_if.source  result
);

  localparam int DEPTH = (MAX_COLUMNS < (1 << COL_W)) ? MAX_COLUMNS : (1 << COL_W);

  logic  clearing;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_head_valid;
  work_t q_push_data;
  work_t q_head;

  mhsu_front #(
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .setup     (setup),
    .clearing  (clearing),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  mhsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  mhsu_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .clearing   (clearing),
    .result     (result)
  );

  a_no_item_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> !item.ready
  ) else $error("item port ready during clearing pass");

  a_no_queue_overflow: assert property (
    @(posedge clk) disable iff (rst) q_push |-> !q_full
  ) else $error("push into full queue");

  a_no_pop_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> !q_pop
  ) else $error("queue popped during clearing pass");

  a_signature_bound: assert property (
    @(posedge clk) disable iff (rst)
      result.valid |-> (result.signature0 <= SENTINEL) && (result.signature1 <= SENTINEL)
                    && (result.signature2 <= SENTINEL) && (result.signature3 <= SENTINEL)
  ) else $error("signature above sentinel");

endmodule

>>> sim/tb_minhash_signature_update_core.sv
module tb_minhash_signature_update_core;
  import mhsu_pkg::*;

  localparam int STORE_COLUMNS = 4096;
  localparam int MAX_GAP       = 4;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS   = 250;
  localparam int COL_SPAN      = 32;
  localparam int REGS_PER_HASH = 2;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH0_OFFSET,
    REG_HASH0_SLOPE,
    REG_HASH1_OFFSET,
    REG_HASH1_SLOPE,
    REG_HASH2_OFFSET,
    REG_HASH2_SLOPE,
    REG_HASH3_OFFSET,
    REG_HASH3_SLOPE
  } coef_reg_t;

  typedef struct {
    cmd_t             command;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } matrix_entry_t;

  typedef struct {
    logic [CFG_IDX_W-1:0] index;
    logic [COEF_W-1:0]    data;
  } coef_write_t;

  logic clk = 1'b0;
  logic rst;

  mhsu_item_if   item_if();
  mhsu_cfg_if    setup_if();
  mhsu_result_if result_if();

  minhash_signature_update_core #(.MAX_COLUMNS(STORE_COLUMNS)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .setup  (setup_if),
    .result (result_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  logic [SIG_W-1:0]  column_min [NUM_HASHES][STORE_COLUMNS];
  logic [COEF_W-1:0] coef_offset [NUM_HASHES];
  logic [COEF_W-1:0] coef_slope [NUM_HASHES];

  matrix_entry_t entry_q[$];
  coef_write_t   coef_q[$];
  sig_row_t      signature_q[$];

  bit idle_enable;
  int error_count;
  int set_count;
  int read_count;
  int coef_writes;
  int results_checked;
  int cycle_count;
  int entry_gap;
  int coef_gap;
  int result_stall;
  matrix_entry_t cur_entry;
  coef_write_t   cur_write;
  sig_row_t      got_sig;
  sig_row_t      want_sig;

  function automatic sig_row_t update_signature(cmd_t command, logic [ROW_W-1:0] row,
                                                logic [COL_W-1:0] col);
    sig_row_t    sig;
    int unsigned hv;
    for (int k = 0; k < NUM_HASHES; k++) begin
      if (int'(col) >= STORE_COLUMNS) begin
        sig[k] = SENTINEL;
      end else begin
        if (command == CMD_SET) begin
          hv = int'(coef_offset[k]) + int'(coef_slope[k]) * int'(row);
          if (hv < column_min[k][col]) column_min[k][col] = SIG_W'(hv);
        end
        sig[k] = column_min[k][col];
      end
    end
    return sig;
  endfunction

  function automatic void apply_coef_write(logic [CFG_IDX_W-1:0] index,
                                           logic [COEF_W-1:0] data);
    int k;
    k = int'(index) / REGS_PER_HASH;
    // Drop writes past the last coefficient register
    if (int'(index) < NUM_CFG_REGS) begin
      if (int'(index) % REGS_PER_HASH == int'(REG_HASH0_SLOPE)) coef_slope[k] = data;
      else coef_offset[k] = data;
    end
  endfunction

  task automatic push_entry(cmd_t command, int row, int col);
    matrix_entry_t e;
    e.command = command;
    e.row     = ROW_W'(row);
    e.col     = COL_W'(col);
    entry_q.push_back(e);
  endtask

  task automatic push_coef(logic [CFG_IDX_W-1:0] index, logic [COEF_W-1:0] data);
    coef_write_t w;
    w.index = index;
    w.data  = data;
    coef_q.push_back(w);
  endtask

  task automatic set_hash(int k, logic [COEF_W-1:0] offset, logic [COEF_W-1:0] slope);
    push_coef(CFG_IDX_W'(int'(REG_HASH0_OFFSET) + REGS_PER_HASH * k), offset);
    push_coef(CFG_IDX_W'(int'(REG_HASH0_SLOPE) + REGS_PER_HASH * k), slope);
  endtask

  task automatic queue_random_entries(int count, int col_base);
    matrix_entry_t e;
    for (int n = 0; n < count; n++) begin
      e.command = ($urandom_range(0, 3) == 0) ? CMD_READ : CMD_SET;
      e.row = ($urandom_range(0, 1) == 0) ? ROW_W'($urandom_range(0, 63)) : ROW_W'($urandom);
      // Keep most updates on a narrow band of columns so minima get revisited
      e.col = ($urandom_range(0, 4) == 0) ? COL_W'($urandom)
                                          : COL_W'(col_base + $urandom_range(0, COL_SPAN - 1));
      entry_q.push_back(e);
    end
  endtask

  task automatic wait_idle();
    while (entry_q.size() != 0 || item_if.valid || signature_q.size() != 0 ||
           coef_q.size() != 0 || setup_if.valid)
      @(negedge clk);
  endtask

  // Item driver
  always @(posedge clk) begin
    if (rst) begin
      item_if.valid <= 1'b0;
      entry_gap = 0;
    end else begin
      if (item_if.valid && item_if.ready) begin
        signature_q.push_back(update_signature(cmd_t'(item_if.command), item_if.row_index,
                                               item_if.col_index));
        if (cmd_t'(item_if.command) == CMD_SET) set_count++;
        else read_count++;
      end
      if (!item_if.valid || item_if.ready) begin
        if (entry_gap > 0) begin
          entry_gap--;
          item_if.valid <= 1'b0;
        end else if (entry_q.size() != 0) begin
          cur_entry = entry_q.pop_front();
          item_if.valid     <= 1'b1;
          item_if.command   <= cur_entry.command;
          item_if.row_index <= cur_entry.row;
          item_if.col_index <= cur_entry.col;
          entry_gap = idle_enable ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // Coefficient register driver
  always @(posedge clk) begin
    if (rst) begin
      setup_if.valid <= 1'b0;
      coef_gap = 0;
    end else begin
      if (setup_if.valid && setup_if.ready) begin
        apply_coef_write(setup_if.index, setup_if.data);
        coef_writes++;
      end
      if (!setup_if.valid || setup_if.ready) begin
        if (coef_gap > 0) begin
          coef_gap--;
          setup_if.valid <= 1'b0;
        end else if (coef_q.size() != 0) begin
          cur_write = coef_q.pop_front();
          setup_if.valid <= 1'b1;
          setup_if.index <= cur_write.index;
          setup_if.data  <= cur_write.data;
          coef_gap = idle_enable ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
          setup_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst) begin
      result_if.ready <= 1'b0;
      result_stall = 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        got_sig = {result_if.signature3, result_if.signature2,
                   result_if.signature1, result_if.signature0};
        if (signature_q.size() == 0) begin
          $error("result transfer with no item outstanding");
          error_count++;
        end else begin
          want_sig = signature_q.pop_front();
          for (int k = 0; k < NUM_HASHES; k++) begin
            if (got_sig[k] !== want_sig[k]) begin
              $error("signature%0d: expected %0d, got %0d", k, want_sig[k], got_sig[k]);
              error_count++;
            end
          end
        end
        results_checked++;
        result_stall = idle_enable ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (result_stall > 0) begin
        result_stall--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             signature_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int col_base;
    rst                 = 1'b1;
    item_if.valid       = 1'b0;
    item_if.command     = CMD_SET;
    item_if.row_index   = '0;
    item_if.col_index   = '0;
    setup_if.valid      = 1'b0;
    setup_if.index      = '0;
    setup_if.data       = '0;
    result_if.ready     = 1'b0;
    idle_enable         = 1'b1;
    for (int k = 0; k < NUM_HASHES; k++) begin
      coef_offset[k] = COEF_INIT;
      coef_slope[k]  = COEF_INIT;
      for (int c = 0; c < STORE_COLUMNS; c++) column_min[k][c] = SENTINEL;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset coefficients: every hash is row + 1
    push_entry(CMD_READ, 0, 0);
    push_entry(CMD_SET, 0, 0);
    push_entry(CMD_SET, 4095, 0);
    push_entry(CMD_SET, 4095, 4095);
    push_entry(CMD_SET, 0, 4095);
    push_entry(CMD_SET, 0, 4095);
    push_entry(CMD_READ, 4095, 4095);
    push_entry(CMD_SET, 2048, 1);
    push_entry(CMD_SET, 1, 1);
    wait_idle();

    // Hash 0 lands exactly on the sentinel at row 392; hash 1 overshoots it
    set_hash(0, 8'd39, 8'd255);
    set_hash(1, 8'd255, 8'd255);
    set_hash(2, 8'd0, 8'd0);
    set_hash(3, 8'd255, 8'd0);
    push_coef(CFG_IDX_W'(NUM_CFG_REGS), 8'hFF);
    push_coef('1, 8'h00);
    wait_idle();
    push_entry(CMD_SET, 392, 2);
    push_entry(CMD_SET, 391, 2);
    push_entry(CMD_SET, 4095, 2);
    push_entry(CMD_READ, 0, 2);
    push_entry(CMD_SET, 392, 3);
    push_entry(CMD_SET, 0, 3);
    push_entry(CMD_READ, 4095, 1);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_enable = (p % 2 == 0) || (p == RANDOM_PHASES - 2);
      for (int k = 0; k < NUM_HASHES; k++) begin
        case (p)
          0: set_hash(k, 8'hFF, 8'hFF);
          1: set_hash(k, 8'h00, 8'h00);
          2: set_hash(k, COEF_W'($urandom), COEF_W'($urandom_range(0, 3)));
          3: set_hash(k, COEF_W'($urandom), COEF_W'($urandom));
          default: set_hash(k, COEF_W'($urandom), COEF_W'($urandom_range(0, 15)));
        endcase
      end
      if ($urandom_range(0, 1) == 0)
        push_coef(CFG_IDX_W'($urandom_range(NUM_CFG_REGS, (1 << CFG_IDX_W) - 1)),
                  COEF_W'($urandom));
      wait_idle();
      col_base = 16 + p * 512;
      queue_random_entries(PHASE_ITEMS, col_base);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d set and %0d read items, %0d coefficient writes incl. unused indexes",
             set_count, read_count, coef_writes);
    $display("checked %0d signature results with extreme and random coefficients",
             results_checked);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
